// ----- rtl/sfla_pkg.sv -----
package sfla_pkg;

	localparam int MaxBytes    = 128;
	localparam int Align       = 8;
	localparam int NumClasses  = 16;
	localparam int RefillCount = 20;
	localparam int ArenaBytes  = 65536;
	localparam int ChunkObjs   = 16;

	localparam int ChunkBytes = MaxBytes * ChunkObjs + Align;
	localparam int AlignLg    = $clog2(Align);
	localparam int LinkDepth  = (ArenaBytes + Align - 1) / Align;
	localparam int LinkAw     = $clog2(LinkDepth);
	localparam int ClsW       = $clog2(NumClasses);
	localparam int CntW       = $clog2(RefillCount + 1);
	localparam int PtrW       = $clog2(ArenaBytes + 1);
	localparam int SumW       = PtrW + 1;
	localparam int SizeW      = 8;
	localparam int AddrW      = 16;
	localparam int UsedW      = 16;
	localparam int RszW       = SizeW + 1;

	localparam logic CmdAlloc = 1'b0;
	localparam logic CmdFree  = 1'b1;

	localparam logic [1:0] StatusOk        = 2'd0;
	localparam logic [1:0] StatusTooLarge  = 2'd1;
	localparam logic [1:0] StatusExhausted = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_COUNT,
		ST_LINK,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/sfla_if.sv -----
interface sfla_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  size;
	logic [15:0] address;

	modport source (output valid, output command, output size, output address, input ready);
	modport sink (input valid, input command, input size, input address, output ready);
endinterface

interface sfla_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] address_res;
	logic [1:0]  status;
	logic [15:0] used_bytes;

	modport source (output valid, output address_res, output status, output used_bytes,
		input ready);
	modport sink (input valid, input address_res, input status, input used_bytes,
		output ready);
endinterface

// ----- rtl/segregated_free_list_allocator.sv -----
// Pool allocator over a 64 KiB byte arena with one LIFO free list per 8-byte size class.
// One request is in work at a time; req.ready is high only while the sequencer is idle,
// and a finished response waits in an output register so the next request can enter.
// A deallocate or an oversize request goes from EXEC straight to DONE; an allocate served
// from a free list passes through POP. An allocate that finds its list empty walks the
// current chunk with one shared adder, one object per cycle, to count up to 20 objects
// (plus the count of a fresh chunk when the old one is used up), then writes one link per
// cycle into the link memory, which has separate read and write ports, for all carved
// objects after the first. The link memory needs no clearing after reset.
module segregated_free_list_allocator (
	input  logic       clk,
	input  logic       arst_n,
	sfla_req_if.sink   req,
	sfla_rsp_if.source rsp
);

	sfla_pkg::state_t state_q, state_d;

	logic                                            cmd_q;
	logic [sfla_pkg::SizeW-1:0]                      size_q;
	logic [sfla_pkg::AddrW-1:0]                      addr_q;
	logic [sfla_pkg::RszW-1:0]                       rsz_q;
	logic [sfla_pkg::ClsW-1:0]                       cls_q;
	logic                                            bad_q;

	logic [sfla_pkg::AddrW-1:0] heads_q [sfla_pkg::NumClasses];
	logic [sfla_pkg::PtrW-1:0]  carve_start_q, carve_end_q, ncb_q;
	logic [sfla_pkg::UsedW-1:0] used_q;
	logic [sfla_pkg::PtrW-1:0]  walk_q, ptr_q;
	logic [sfla_pkg::CntW-1:0]  cnt_q, idx_q;
	logic                       opened_q;
	logic [sfla_pkg::AddrW-1:0] res_q;
	logic [1:0]                 status_q;

	logic                       out_valid_q;
	logic [sfla_pkg::AddrW-1:0] out_addr_q;
	logic [1:0]                 out_status_q;
	logic [sfla_pkg::UsedW-1:0] out_used_q;

	logic [sfla_pkg::AddrW-1:0] link_mem [sfla_pkg::LinkDepth];
	logic [sfla_pkg::AddrW-1:0] link_rdata;
	logic                       mem_we;
	logic [sfla_pkg::LinkAw-1:0] mem_waddr, mem_raddr;
	logic [sfla_pkg::AddrW-1:0] mem_wdata;

	// request decode
	logic [sfla_pkg::RszW-1:0] round_sum, rsz_d, cls_full;
	logic                      bad_d;

	// shared adder and chunk check
	logic [sfla_pkg::PtrW-1:0] opnd;
	logic [sfla_pkg::SumW-1:0] step_sum, chunk_sum, first_sum;
	logic                      fits, chunk_ok, slot_free, link_last;
	logic [sfla_pkg::CntW-1:0] idx_next;
	logic [sfla_pkg::AddrW-1:0] head_cur;
	logic [sfla_pkg::UsedW:0]  used_add;
	logic [sfla_pkg::UsedW-1:0] used_inc, used_dec;

	always_comb begin
		round_sum = {1'b0, req.size} + sfla_pkg::RszW'(sfla_pkg::Align - 1);
		rsz_d = (round_sum >> sfla_pkg::AlignLg) << sfla_pkg::AlignLg;
		if (rsz_d == '0) begin
			rsz_d = sfla_pkg::RszW'(sfla_pkg::Align);
		end
		cls_full = (rsz_d >> sfla_pkg::AlignLg) - sfla_pkg::RszW'(1);
		bad_d = ({1'b0, req.size} > sfla_pkg::RszW'(sfla_pkg::MaxBytes))
			|| (cls_full >= sfla_pkg::RszW'(sfla_pkg::NumClasses));
	end

	always_comb begin
		opnd      = (state_q == sfla_pkg::ST_LINK) ? ptr_q : walk_q;
		step_sum  = {1'b0, opnd} + sfla_pkg::SumW'(rsz_q);
		first_sum = {1'b0, carve_start_q} + sfla_pkg::SumW'(rsz_q);
		chunk_sum = {1'b0, ncb_q} + sfla_pkg::SumW'(sfla_pkg::ChunkBytes);
		chunk_ok  = chunk_sum <= sfla_pkg::SumW'(sfla_pkg::ArenaBytes);
		fits      = (cnt_q < sfla_pkg::CntW'(sfla_pkg::RefillCount))
			&& (step_sum <= {1'b0, carve_end_q});
		idx_next  = idx_q + sfla_pkg::CntW'(1);
		link_last = idx_next == cnt_q;
		head_cur  = heads_q[cls_q];
		slot_free = !out_valid_q || rsp.ready;
		used_add  = {1'b0, used_q} + (sfla_pkg::UsedW + 1)'(size_q);
		used_inc  = used_add[sfla_pkg::UsedW] ? '1 : used_add[sfla_pkg::UsedW-1:0];
		used_dec  = (used_q > sfla_pkg::UsedW'(size_q))
			? used_q - sfla_pkg::UsedW'(size_q) : '0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sfla_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = sfla_pkg::ST_EXEC;
				end
			end
			sfla_pkg::ST_EXEC: begin
				priority if (bad_q || cmd_q == sfla_pkg::CmdFree) begin
					state_d = sfla_pkg::ST_DONE;
				end else if (head_cur != '0) begin
					state_d = sfla_pkg::ST_POP;
				end else begin
					state_d = sfla_pkg::ST_COUNT;
				end
			end
			sfla_pkg::ST_POP: state_d = sfla_pkg::ST_DONE;
			sfla_pkg::ST_COUNT: begin
				priority if (fits) begin
					state_d = sfla_pkg::ST_COUNT;
				end else if (cnt_q == '0) begin
					state_d = (opened_q || !chunk_ok) ? sfla_pkg::ST_DONE : sfla_pkg::ST_COUNT;
				end else if (cnt_q > sfla_pkg::CntW'(1)) begin
					state_d = sfla_pkg::ST_LINK;
				end else begin
					state_d = sfla_pkg::ST_DONE;
				end
			end
			sfla_pkg::ST_LINK: begin
				if (link_last) begin
					state_d = sfla_pkg::ST_DONE;
				end
			end
			sfla_pkg::ST_DONE: begin
				if (slot_free) begin
					state_d = sfla_pkg::ST_IDLE;
				end
			end
			default: state_d = sfla_pkg::ST_IDLE;
		endcase
	end

	// outputs and memory control
	always_comb begin
		req.ready = state_q == sfla_pkg::ST_IDLE;
		mem_we    = 1'b0;
		mem_waddr = addr_q[sfla_pkg::AlignLg +: sfla_pkg::LinkAw];
		mem_wdata = head_cur;
		mem_raddr = head_cur[sfla_pkg::AlignLg +: sfla_pkg::LinkAw];
		unique case (state_q)
			sfla_pkg::ST_EXEC: begin
				mem_we = !bad_q && cmd_q == sfla_pkg::CmdFree && addr_q != '0;
			end
			sfla_pkg::ST_LINK: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q[sfla_pkg::AlignLg +: sfla_pkg::LinkAw];
				mem_wdata = link_last ? '0 : step_sum[sfla_pkg::AddrW-1:0];
			end
			default: ;
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.address_res = out_addr_q;
	assign rsp.status      = out_status_q;
	assign rsp.used_bytes  = out_used_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		link_rdata <= link_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= sfla_pkg::ST_IDLE;
			cmd_q         <= sfla_pkg::CmdAlloc;
			size_q        <= '0;
			addr_q        <= '0;
			rsz_q         <= '0;
			cls_q         <= '0;
			bad_q         <= 1'b0;
			for (int i = 0; i < sfla_pkg::NumClasses; i++) begin
				heads_q[i] <= '0;
			end
			carve_start_q <= '0;
			carve_end_q   <= '0;
			ncb_q         <= '0;
			used_q        <= '0;
			walk_q        <= '0;
			ptr_q         <= '0;
			cnt_q         <= '0;
			idx_q         <= '0;
			opened_q      <= 1'b0;
			res_q         <= '0;
			status_q      <= sfla_pkg::StatusOk;
			out_valid_q   <= 1'b0;
			out_addr_q    <= '0;
			out_status_q  <= sfla_pkg::StatusOk;
			out_used_q    <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && rsp.ready && state_q != sfla_pkg::ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				sfla_pkg::ST_IDLE: begin
					if (req.valid) begin
						cmd_q  <= req.command;
						size_q <= req.size;
						addr_q <= req.address;
						rsz_q  <= rsz_d;
						cls_q  <= cls_full[sfla_pkg::ClsW-1:0];
						bad_q  <= bad_d;
					end
				end
				sfla_pkg::ST_EXEC: begin
					priority if (bad_q) begin
						res_q    <= '0;
						status_q <= sfla_pkg::StatusTooLarge;
					end else if (cmd_q == sfla_pkg::CmdFree) begin
						res_q    <= '0;
						status_q <= sfla_pkg::StatusOk;
						if (addr_q != '0) begin
							heads_q[cls_q] <= addr_q;
							used_q         <= used_dec;
						end
					end else if (head_cur != '0) begin
						res_q    <= head_cur;
						status_q <= sfla_pkg::StatusOk;
					end else begin
						res_q    <= '0;
						status_q <= sfla_pkg::StatusOk;
						walk_q   <= carve_start_q;
						cnt_q    <= '0;
						opened_q <= 1'b0;
					end
				end
				sfla_pkg::ST_POP: begin
					heads_q[cls_q] <= link_rdata;
					used_q         <= used_inc;
				end
				sfla_pkg::ST_COUNT: begin
					priority if (fits) begin
						walk_q <= step_sum[sfla_pkg::PtrW-1:0];
						cnt_q  <= cnt_q + sfla_pkg::CntW'(1);
					end else if (cnt_q == '0) begin
						if (opened_q || !chunk_ok) begin
							status_q <= sfla_pkg::StatusExhausted;
						end else begin
							// open a fresh chunk, skipping its header
							carve_start_q <= ncb_q + sfla_pkg::PtrW'(sfla_pkg::Align);
							walk_q        <= ncb_q + sfla_pkg::PtrW'(sfla_pkg::Align);
							carve_end_q   <= chunk_sum[sfla_pkg::PtrW-1:0];
							ncb_q         <= chunk_sum[sfla_pkg::PtrW-1:0];
							opened_q      <= 1'b1;
						end
					end else begin
						res_q         <= carve_start_q[sfla_pkg::AddrW-1:0];
						used_q        <= used_inc;
						carve_start_q <= walk_q;
						ptr_q         <= first_sum[sfla_pkg::PtrW-1:0];
						idx_q         <= sfla_pkg::CntW'(1);
						if (cnt_q > sfla_pkg::CntW'(1)) begin
							heads_q[cls_q] <= first_sum[sfla_pkg::AddrW-1:0];
						end
					end
				end
				sfla_pkg::ST_LINK: begin
					ptr_q <= step_sum[sfla_pkg::PtrW-1:0];
					idx_q <= idx_next;
				end
				sfla_pkg::ST_DONE: begin
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_addr_q   <= res_q;
						out_status_q <= status_q;
						out_used_q   <= used_q;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/sfla_checker.sv -----
module sfla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] address_res,
	input logic [1:0]  status,
	input logic [15:0] used_bytes
);

	// a failed request never hands out an object
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != sfla_pkg::StatusOk |-> address_res == '0)
		else $error("failed request returned an address");

	// status carries one of the three codes
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status == sfla_pkg::StatusOk || status == sfla_pkg::StatusTooLarge
			|| status == sfla_pkg::StatusExhausted)
		else $error("unknown status code");

	// a stalled response holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(address_res) && $stable(status)
			&& $stable(used_bytes))
		else $error("stalled response changed");

endmodule

bind segregated_free_list_allocator sfla_checker u_sfla_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.address_res (rsp.address_res),
	.status      (rsp.status),
	.used_bytes  (rsp.used_bytes)
);
